FILE: rtl/ssfs_pkg.sv
package ssfs_pkg;

    // Item and tap geometry.
    localparam int TAP_COUNT      = 20;
    localparam int SAMPLE_BITS    = 24;
    localparam int STATE_BITS     = SAMPLE_BITS + 4;
    localparam int TAP_IDX_BITS   = $clog2(TAP_COUNT);
    localparam int TDATA_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_BITS       = 17;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIM = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WET  = 1'b1;

    // Coefficient widths.
    localparam int WT_BITS        = 18;
    localparam int FF_BITS        = 17;
    localparam int CUBE_BITS      = 17;
    localparam int ONEMC_BITS     = 18;
    localparam int OS_BITS        = 21;
    localparam int GAIN_BITS      = 22;
    localparam int QUO_BITS       = WT_BITS;
    localparam int NUM_BITS       = 34;
    localparam int DEN_BITS       = OS_BITS;

    // Shared multiplier and accumulator.
    localparam int MUL_A_BITS     = STATE_BITS + 1;
    localparam int MUL_B_BITS     = WT_BITS + 1;
    localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS       = PROD_BITS + TAP_IDX_BITS;

    localparam int Q16_ONE        = 65536;
    localparam int CUBE_K         = 12312;
    localparam logic [FF_BITS-1:0]  FF_MAX       = '1;
    localparam logic [CFG_BITS-1:0] Q16_ONE_CFG  = CFG_BITS'(Q16_ONE);

    localparam logic signed [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(32768);
    localparam logic signed [ACC_BITS-1:0]  ACC_HALF  = ACC_BITS'(65536);
    localparam logic signed [ACC_BITS-1:0]  ST_MAX    =
        (ACC_BITS'(1) <<< (STATE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0]  ST_MIN    = ~ST_MAX;
    localparam logic signed [PROD_BITS-1:0] SMP_MAX   =
        (PROD_BITS'(1) <<< (SAMPLE_BITS - 1)) - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] SMP_MIN   = ~SMP_MAX;

    typedef struct packed {
        logic signed [MUL_A_BITS-1:0] a;
        logic signed [MUL_B_BITS-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] numer;
        logic [DEN_BITS-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } seq_res_t;

    // Round half up, dropping 16 fraction bits.
    function automatic logic signed [PROD_BITS-1:0] rnd16(
        input logic signed [PROD_BITS-1:0] x);
        return (x + PROD_HALF) >>> 16;
    endfunction

    // Round half up, dropping 17 fraction bits.
    function automatic logic signed [ACC_BITS-1:0] rnd17(
        input logic signed [ACC_BITS-1:0] x);
        return (x + ACC_HALF) >>> 17;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] c;
        c = v;
        if (v > ST_MAX)
        begin
            c = ST_MAX;
        end
        else if (v < ST_MIN)
        begin
            c = ST_MIN;
        end
        return c[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [PROD_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] c;
        c = v;
        if (v > SMP_MAX)
        begin
            c = SMP_MAX;
        end
        else if (v < SMP_MIN)
        begin
            c = SMP_MIN;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/ssfs_mul.sv
module ssfs_mul (
    input  logic                                  clk,
    input  ssfs_pkg::mul_req_t                    req,
    output logic signed [ssfs_pkg::PROD_BITS-1:0] prod
);
    import ssfs_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg;

    // Signed multiply with a registered product; the sequencer reads it in the
    // cycle after it drives the operands.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(req.a) * PROD_BITS'(req.b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/ssfs_div.sv
module ssfs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ssfs_pkg::div_req_t req,
    output ssfs_pkg::div_rsp_t rsp
);
    import ssfs_pkg::*;

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] low_reg, low_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS:0]   trial;

    // Restoring division, one quotient bit per cycle. The upper dividend bits
    // are known to be below the divisor, so only QUO_BITS steps are needed.
    // Dividend bits shift out of low_reg as quotient bits shift in.
    assign trial = {rem_reg, low_reg[QUO_BITS-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            cnt_next = CNT_BITS'(QUO_BITS);
            rem_next = DEN_BITS'(req.numer[NUM_BITS-1:QUO_BITS]);
            low_next = req.numer[QUO_BITS-1:0];
            den_next = req.denom;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_BITS'(1);
            done_next = (cnt_reg == CNT_BITS'(1));
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_BITS'(trial - {1'b0, den_reg});
                low_next = {low_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_BITS-1:0];
                low_next = {low_reg[QUO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = low_reg;

endmodule

FILE: rtl/ssfs_seq.sv
module ssfs_seq (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [ssfs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [ssfs_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [ssfs_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [ssfs_pkg::SAMPLE_BITS-1:0] right_sample,
    input  logic                                    slot_free,
    output ssfs_pkg::seq_res_t                      res,
    output ssfs_pkg::mul_req_t                      mul_req,
    input  logic signed [ssfs_pkg::PROD_BITS-1:0]   prod,
    output ssfs_pkg::div_req_t                      div_req,
    input  ssfs_pkg::div_rsp_t                      div_rsp
);
    import ssfs_pkg::*;

    localparam int ST_BITS = 5;
    localparam logic [ST_BITS-1:0] ST_IDLE    = 5'd0;
    localparam logic [ST_BITS-1:0] ST_D_START = 5'd1;
    localparam logic [ST_BITS-1:0] ST_D_R1    = 5'd2;
    localparam logic [ST_BITS-1:0] ST_D_M2    = 5'd3;
    localparam logic [ST_BITS-1:0] ST_D_R2    = 5'd4;
    localparam logic [ST_BITS-1:0] ST_D_M3    = 5'd5;
    localparam logic [ST_BITS-1:0] ST_D_R3    = 5'd6;
    localparam logic [ST_BITS-1:0] ST_D_GAIN  = 5'd7;
    localparam logic [ST_BITS-1:0] ST_D_ADJM  = 5'd8;
    localparam logic [ST_BITS-1:0] ST_D_ADJR  = 5'd9;
    localparam logic [ST_BITS-1:0] ST_D_FFM   = 5'd10;
    localparam logic [ST_BITS-1:0] ST_D_FFR   = 5'd11;
    localparam logic [ST_BITS-1:0] ST_D_TAP   = 5'd12;
    localparam logic [ST_BITS-1:0] ST_D_TAPW  = 5'd13;
    localparam logic [ST_BITS-1:0] ST_SLOPE   = 5'd14;
    localparam logic [ST_BITS-1:0] ST_CORR    = 5'd15;
    localparam logic [ST_BITS-1:0] ST_MAC     = 5'd16;
    localparam logic [ST_BITS-1:0] ST_MACEND  = 5'd17;
    localparam logic [ST_BITS-1:0] ST_VEL1    = 5'd18;
    localparam logic [ST_BITS-1:0] ST_VEL2    = 5'd19;
    localparam logic [ST_BITS-1:0] ST_POS     = 5'd20;
    localparam logic [ST_BITS-1:0] ST_FB      = 5'd21;
    localparam logic [ST_BITS-1:0] ST_MIX1    = 5'd22;
    localparam logic [ST_BITS-1:0] ST_MIX2    = 5'd23;
    localparam logic [ST_BITS-1:0] ST_DONE    = 5'd24;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(Q16_ONE);
    localparam logic [OS_BITS-1:0]   OS_ONE   = OS_BITS'(Q16_ONE);
    localparam logic signed [ONEMC_BITS-1:0] ONEMC_ONE = ONEMC_BITS'(Q16_ONE);

    // Control.
    logic [ST_BITS-1:0]      state_reg, state_next;
    logic [TAP_IDX_BITS-1:0] idx_reg, idx_next;
    logic                    ch_reg, ch_next;
    logic                    pend_reg, pend_next;

    // Configuration and derived coefficients.
    logic [CFG_BITS-1:0]          trim_reg, trim_next;
    logic [CFG_BITS-1:0]          wet_reg, wet_next;
    logic [OS_BITS-1:0]           os_reg, os_next;
    logic [CUBE_BITS-1:0]         cube_reg, cube_next;
    logic signed [ONEMC_BITS-1:0] onemc_reg, onemc_next;
    logic [GAIN_BITS-1:0]         gain_reg, gain_next;
    logic [DEN_BITS-1:0]          div_reg, div_next;
    logic [FF_BITS-1:0]           ff_reg, ff_next;
    logic signed [MUL_A_BITS-1:0] tmp_reg, tmp_next;
    logic [WT_BITS-1:0]           wt_mem [TAP_COUNT];

    // Filter state.
    logic signed [STATE_BITS-1:0] hist_l_reg [TAP_COUNT];
    logic signed [STATE_BITS-1:0] hist_r_reg [TAP_COUNT];
    logic signed [STATE_BITS-1:0] last_l_reg, last_l_next;
    logic signed [STATE_BITS-1:0] last_r_reg, last_r_next;
    logic signed [STATE_BITS-1:0] prior_l_reg, prior_l_next;
    logic signed [STATE_BITS-1:0] prior_r_reg, prior_r_next;

    // Per-item working registers.
    logic signed [SAMPLE_BITS-1:0] in_l_reg, in_l_next;
    logic signed [SAMPLE_BITS-1:0] in_r_reg, in_r_next;
    logic signed [STATE_BITS-1:0]  slope_reg, slope_next;
    logic signed [STATE_BITS-1:0]  accq_reg, accq_next;
    logic signed [STATE_BITS-1:0]  vel_reg, vel_next;
    logic signed [STATE_BITS-1:0]  pos_reg, pos_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [PROD_BITS-1:0]   mixa_reg, mixa_next;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_l_next;
    logic signed [SAMPLE_BITS-1:0] out_r_reg, out_r_next;

    // Combinational helpers.
    logic signed [STATE_BITS-1:0]  cur_last, cur_prior, hist_rd;
    logic signed [SAMPLE_BITS-1:0] cur_in;
    logic [WT_BITS-1:0]            wt_rd;
    logic signed [PROD_BITS-1:0]   prod_rnd, fb_rnd, mix_rnd;
    logic signed [MUL_B_BITS-1:0]  dry_gain;
    logic signed [STATE_BITS-1:0]  corr_val, pos_val, prior_val;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic [GAIN_BITS-1:0]          gain_sum;
    logic [CUBE_BITS-1:0]          raw_wt;
    logic                          hist_shift;
    logic                          wt_write;

    assign cur_last  = ch_reg ? last_r_reg  : last_l_reg;
    assign cur_prior = ch_reg ? prior_r_reg : prior_l_reg;
    assign cur_in    = ch_reg ? in_r_reg    : in_l_reg;
    assign hist_rd   = ch_reg ? hist_r_reg[idx_reg] : hist_l_reg[idx_reg];
    assign wt_rd     = wt_mem[idx_reg];

    assign prod_rnd  = rnd16(prod);
    assign fb_rnd    = rnd16(-prod);
    assign mix_rnd   = rnd16(mixa_reg + prod);
    assign dry_gain  = signed'(MUL_B_BITS'(Q16_ONE)) - signed'(MUL_B_BITS'(wet_reg));

    assign corr_val  = sat_state(ACC_BITS'(cur_prior) - ACC_BITS'(slope_reg));
    assign pos_val   = sat_state(ACC_BITS'(cur_last) + ACC_BITS'(vel_reg));
    assign prior_val = sat_state(ACC_BITS'(fb_rnd));
    assign out_val   = sat_sample(mix_rnd);
    assign gain_sum  = GAIN_BITS'(os_reg) + GAIN_BITS'(cube_reg);
    assign raw_wt    = (gain_reg > GAIN_ONE) ? Q16_ONE_CFG : gain_reg[CUBE_BITS-1:0];

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_wr_en;

    assign res.valid = (state_reg == ST_DONE);
    assign res.left  = out_l_reg;
    assign res.right = out_r_reg;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ch_next      = ch_reg;
        pend_next    = 1'b0;
        trim_next    = trim_reg;
        wet_next     = wet_reg;
        os_next      = os_reg;
        cube_next    = cube_reg;
        onemc_next   = onemc_reg;
        gain_next    = gain_reg;
        div_next     = div_reg;
        ff_next      = ff_reg;
        tmp_next     = tmp_reg;
        last_l_next  = last_l_reg;
        last_r_next  = last_r_reg;
        prior_l_next = prior_l_reg;
        prior_r_next = prior_r_reg;
        in_l_next    = in_l_reg;
        in_r_next    = in_r_reg;
        slope_next   = slope_reg;
        accq_next    = accq_reg;
        vel_next     = vel_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        mixa_next    = mixa_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        hist_shift   = 1'b0;
        wt_write     = 1'b0;
        mul_req      = '0;
        div_req      = '0;

        // A tap product issued last cycle lands in the accumulator now.
        if (pend_reg)
        begin
            acc_next = acc_reg + ACC_BITS'(prod);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    in_l_next  = left_sample;
                    in_r_next  = right_sample;
                    ch_next    = 1'b0;
                    state_next = ST_SLOPE;
                end
            end
            // Coefficient derivation: cube of the wet knob first.
            ST_D_START:
            begin
                mul_req.a  = MUL_A_BITS'(wet_reg);
                mul_req.b  = MUL_B_BITS'(wet_reg);
                os_next    = OS_BITS'({trim_reg, 3'b000}) + OS_BITS'({trim_reg, 1'b0});
                state_next = ST_D_R1;
            end
            ST_D_R1:
            begin
                tmp_next   = MUL_A_BITS'(prod_rnd);
                state_next = ST_D_M2;
            end
            ST_D_M2:
            begin
                mul_req.a  = tmp_reg;
                mul_req.b  = MUL_B_BITS'(wet_reg);
                state_next = ST_D_R2;
            end
            ST_D_R2:
            begin
                tmp_next   = MUL_A_BITS'(prod_rnd);
                state_next = ST_D_M3;
            end
            ST_D_M3:
            begin
                mul_req.a  = tmp_reg;
                mul_req.b  = MUL_B_BITS'(CUBE_K);
                state_next = ST_D_R3;
            end
            ST_D_R3:
            begin
                cube_next  = prod_rnd[CUBE_BITS-1:0];
                state_next = ST_D_GAIN;
            end
            ST_D_GAIN:
            begin
                gain_next  = (gain_sum < GAIN_ONE) ? GAIN_ONE : gain_sum;
                div_next   = (os_reg < OS_ONE) ? OS_ONE : os_reg;
                onemc_next = ONEMC_ONE - signed'(ONEMC_BITS'(cube_reg));
                state_next = ST_D_ADJM;
            end
            ST_D_ADJM:
            begin
                mul_req.a  = MUL_A_BITS'(trim_reg);
                mul_req.b  = MUL_B_BITS'(onemc_reg);
                state_next = ST_D_ADJR;
            end
            ST_D_ADJR:
            begin
                tmp_next   = MUL_A_BITS'(prod_rnd);
                state_next = ST_D_FFM;
            end
            ST_D_FFM:
            begin
                mul_req.a  = tmp_reg;
                mul_req.b  = MUL_B_BITS'(tmp_reg);
                state_next = ST_D_FFR;
            end
            ST_D_FFR:
            begin
                ff_next    = (prod_rnd > PROD_BITS'(FF_MAX)) ? FF_MAX :
                             prod_rnd[FF_BITS-1:0];
                idx_next   = '0;
                state_next = ST_D_TAP;
            end
            // Hand out the gain one whole tap at a time, then divide.
            ST_D_TAP:
            begin
                gain_next     = (gain_reg > GAIN_ONE) ? (gain_reg - GAIN_ONE) : '0;
                div_req.start = 1'b1;
                div_req.numer = {raw_wt, 17'b0} + NUM_BITS'(div_reg >> 1);
                div_req.denom = div_reg;
                state_next    = ST_D_TAPW;
            end
            ST_D_TAPW:
            begin
                if (div_rsp.done)
                begin
                    wt_write = 1'b1;
                    if (idx_reg == TAP_IDX_BITS'(TAP_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TAP_IDX_BITS'(1);
                        state_next = ST_D_TAP;
                    end
                end
            end
            // Per-channel filter pass.
            ST_SLOPE:
            begin
                slope_next = sat_state(ACC_BITS'(cur_last) - ACC_BITS'(cur_in));
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                hist_shift = 1'b1;
                acc_next   = '0;
                idx_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                mul_req.a = MUL_A_BITS'(hist_rd);
                mul_req.b = MUL_B_BITS'(wt_rd);
                pend_next = 1'b1;
                if (idx_reg == TAP_IDX_BITS'(TAP_COUNT - 1))
                begin
                    state_next = ST_MACEND;
                end
                else
                begin
                    idx_next = idx_reg + TAP_IDX_BITS'(1);
                end
            end
            ST_MACEND:
            begin
                state_next = ST_VEL1;
            end
            ST_VEL1:
            begin
                accq_next  = sat_state(rnd17(acc_reg));
                state_next = ST_VEL2;
            end
            ST_VEL2:
            begin
                vel_next   = sat_state(ACC_BITS'(cur_prior) + ACC_BITS'(accq_reg));
                state_next = ST_POS;
            end
            ST_POS:
            begin
                pos_next = pos_val;
                if (ch_reg)
                begin
                    last_r_next = pos_val;
                end
                else
                begin
                    last_l_next = pos_val;
                end
                mul_req.a  = MUL_A_BITS'(vel_reg);
                mul_req.b  = MUL_B_BITS'(ff_reg);
                state_next = ST_FB;
            end
            ST_FB:
            begin
                if (ch_reg)
                begin
                    prior_r_next = prior_val;
                end
                else
                begin
                    prior_l_next = prior_val;
                end
                mul_req.a  = MUL_A_BITS'(pos_reg);
                mul_req.b  = MUL_B_BITS'(wet_reg);
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                mixa_next  = prod;
                mul_req.a  = MUL_A_BITS'(cur_in);
                mul_req.b  = dry_gain;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                if (ch_reg)
                begin
                    out_r_next = out_val;
                    state_next = ST_DONE;
                end
                else
                begin
                    out_l_next = out_val;
                    ch_next    = 1'b1;
                    state_next = ST_SLOPE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the coefficient derivation.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TRIM: trim_next = cfg_data;
                REG_WET:  wet_next  = cfg_data;
                default:  ;
            endcase
            state_next = ST_D_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_D_START;
            idx_reg     <= '0;
            ch_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            trim_reg    <= Q16_ONE_CFG;
            wet_reg     <= Q16_ONE_CFG;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
            prior_l_reg <= '0;
            prior_r_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ch_reg      <= ch_next;
            pend_reg    <= pend_next;
            trim_reg    <= trim_next;
            wet_reg     <= wet_next;
            last_l_reg  <= last_l_next;
            last_r_reg  <= last_r_next;
            prior_l_reg <= prior_l_next;
            prior_r_reg <= prior_r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else if (hist_shift)
        begin
            if (ch_reg)
            begin
                for (int i = TAP_COUNT - 1; i > 0; i--)
                begin
                    hist_r_reg[i] <= hist_r_reg[i-1];
                end
                hist_r_reg[0] <= corr_val;
            end
            else
            begin
                for (int i = TAP_COUNT - 1; i > 0; i--)
                begin
                    hist_l_reg[i] <= hist_l_reg[i-1];
                end
                hist_l_reg[0] <= corr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        os_reg    <= os_next;
        cube_reg  <= cube_next;
        onemc_reg <= onemc_next;
        gain_reg  <= gain_next;
        div_reg   <= div_next;
        ff_reg    <= ff_next;
        tmp_reg   <= tmp_next;
        in_l_reg  <= in_l_next;
        in_r_reg  <= in_r_next;
        slope_reg <= slope_next;
        accq_reg  <= accq_next;
        vel_reg   <= vel_next;
        pos_reg   <= pos_next;
        acc_reg   <= acc_next;
        mixa_reg  <= mixa_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
        if (wt_write)
        begin
            wt_mem[idx_reg] <= div_rsp.quot;
        end
    end

endmodule

FILE: rtl/stereo_slope_fir_smoother.sv
// Channel   Direction  Signals                                  Request carries
// s_axis    in         s_axis_tvalid/tready/tdata               one stereo sample pair
// m_axis    out        m_axis_tvalid/tready/tdata               one filtered stereo pair
// cfg       in         cfg_wr_en/cfg_index/cfg_data             one register write
//
// From acceptance until its result sits in the output register, an input request is served
// by the shared multiplier, which handles one tap product per cycle for each channel in turn.
// After reset and after every register write the tap weights are derived again, a process
// dominated by the bit-serial divider; s_axis_tready stays low meanwhile.
// A result that waits in the output register does not block the next input request; only
// the following result waits for it.
module stereo_slope_fir_smoother (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [ssfs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ssfs_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0 up: left_sample, right_sample.
    input  logic [ssfs_pkg::TDATA_BITS-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0 up: left_out, right_out.
    output logic [ssfs_pkg::TDATA_BITS-1:0]        m_axis_tdata
);
    import ssfs_pkg::*;

    mul_req_t                    mul_req;
    logic signed [PROD_BITS-1:0] prod;
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;
    seq_res_t                    res;
    logic                        slot_free;

    logic                  out_valid_reg, out_valid_next;
    logic [TDATA_BITS-1:0] out_data_reg, out_data_next;

    // The output register is free when empty or drained in this cycle, so a
    // finished result never waits on a stalled sink longer than necessary.
    assign slot_free = !out_valid_reg || m_axis_tready;

    ssfs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .left_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .right_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .slot_free    (slot_free),
        .res          (res),
        .mul_req      (mul_req),
        .prod         (prod),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    ssfs_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    ssfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res.valid && slot_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = TDATA_BITS'({res.right, res.left});
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: rtl/ssfs_checker.sv
module ssfs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_wr_en,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ssfs_pkg::TDATA_BITS-1:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after an accept");

    // A register write starts a coefficient update, which blocks input.
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_axis_tready)
        else $error("input ready right after a register write");

    // A result cannot appear in the cycle right after its input.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after accept");

    // A new result only follows a cycle in which input was blocked.
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result produced while input was ready");

endmodule

bind stereo_slope_fir_smoother ssfs_checker u_ssfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ssfs_pkg::*;

    // Geometry of the block, taken from its package.
    localparam int SMP  = SAMPLE_BITS;
    localparam int TAPS = TAP_COUNT;

    // Fixed-point constants of the tap derivation.
    localparam longint UNITY         = 65536;
    localparam longint FEEDBACK_CEIL = 131071;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_TICKS = 12;

    // Random requests in each configuration phase after the directed part.
    localparam int PHASE_COUNT      = 9;
    localparam int REQS_PER_PHASE   = 137;

    // The receiver holds off this long once, so that the block fills up and
    // stalls its input.
    localparam int HOLD_CYCLES      = 400;
    localparam int HOLD_AFTER       = 60;

    // A correct run never goes this long without a handshake: the limit outlasts the weight
    // derivation after a write, one request, and the long hold-off above.
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 100;

    // Configuration plan per phase. A negative entry means a random setting.
    // The plan covers both knobs at zero and at full scale, a trim just
    // below 0.1 (where the divisor clamps), and knobs above 1.0.
    localparam int TRIM_PLAN [PHASE_COUNT] =
        '{0, 131071, 6553, 65536, 0, 131071, -1, -1, -1};
    localparam int WET_PLAN  [PHASE_COUNT] =
        '{0, 131071, 65536, 0, 131071, 0, -1, -1, -1};

    // Directed sample pairs: zeros, full scale of both signs, opposite
    // extremes on the two channels, one LSB steps, and a run of alternating
    // extremes that drives the integrator state into saturation, then a
    // quiet tail that lets the state decay.
    localparam logic [SMP-1:0] DIR_LEFT [20] = '{
        24'h000000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
        24'h000001, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000,
        24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h400000,
        24'h555555, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    localparam logic [SMP-1:0] DIR_RIGHT [20] = '{
        24'h000000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
        24'hFFFFFF, 24'h000001, 24'h000000, 24'h800000, 24'h7FFFFF,
        24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hC00000,
        24'hAAAAAA, 24'h000000, 24'h000000, 24'h000000, 24'h000000};

    typedef struct packed {
        logic [SMP-1:0] right;
        logic [SMP-1:0] left;
    } stereo_pair_t;

    // The scoreboard carries its own copy of the filter state and the knob
    // settings. Every accepted request is run through the filter at once and
    // the expected pair is queued; results are matched in order.
    class smoother_scoreboard;
        longint trim_q16;
        longint wet_q16;
        longint history [2][TAPS];
        longint position [2];
        longint velocity [2];
        longint weights [TAPS];
        longint feedback;
        stereo_pair_t expected_pairs [$];
        int mismatches;
        int results_checked;

        function new();
            trim_q16 = UNITY;
            wet_q16 = UNITY;
            mismatches = 0;
            results_checked = 0;
            derive_weights();
        endfunction

        // Round half up while dropping s fraction bits.
        function longint round_shift(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint saturate(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                return hi;
            end
            if (v < lo)
            begin
                return lo;
            end
            return v;
        endfunction

        // The gain is spread over the taps one unit at a time; the tap that
        // gets the remainder carries the fraction. Every weight is then
        // normalized by ten times the trim, clamped to at least 1.0.
        function void derive_weights();
            longint os;
            longint w3;
            longint cube;
            longint gain;
            longint divisor;
            longint raw;
            longint adj;
            longint ff;
            os = trim_q16 * 10;
            w3 = round_shift(round_shift(wet_q16 * wet_q16, 16) * wet_q16, 16);
            cube = round_shift(w3 * CUBE_K, 16);
            gain = os + cube;
            divisor = (os < UNITY) ? UNITY : os;
            if (gain < UNITY)
            begin
                gain = UNITY;
            end
            for (int i = 0; i < TAPS; i++)
            begin
                if (gain > UNITY)
                begin
                    raw = UNITY;
                    gain = gain - UNITY;
                end
                else
                begin
                    raw = gain;
                    gain = 0;
                end
                weights[i] = (raw * (longint'(1) << 17) + divisor / 2) / divisor;
            end
            adj = round_shift(trim_q16 * (UNITY - cube), 16);
            ff = round_shift(adj * adj, 16);
            feedback = (ff > FEEDBACK_CEIL) ? FEEDBACK_CEIL : ff;
        endfunction

        function void apply_write(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_BITS-1:0] value);
            if (index == REG_TRIM)
            begin
                trim_q16 = longint'(value);
            end
            else if (index == REG_WET)
            begin
                wet_q16 = longint'(value);
            end
            derive_weights();
        endfunction

        // One channel: the slope correction enters the history, the FIR
        // output adds to the velocity, the velocity integrates into the
        // position, and the damped negated velocity is kept for next time.
        function longint smooth_channel(int ch, longint sample);
            longint slope;
            longint corr;
            longint acc;
            longint vel;
            longint pos;
            slope = saturate(position[ch] - sample, STATE_BITS);
            corr = saturate(velocity[ch] - slope, STATE_BITS);
            for (int i = TAPS - 1; i > 0; i--)
            begin
                history[ch][i] = history[ch][i - 1];
            end
            history[ch][0] = corr;
            acc = 0;
            for (int i = 0; i < TAPS; i++)
            begin
                acc = acc + history[ch][i] * weights[i];
            end
            acc = saturate(round_shift(acc, 17), STATE_BITS);
            vel = saturate(velocity[ch] + acc, STATE_BITS);
            pos = saturate(position[ch] + vel, STATE_BITS);
            position[ch] = pos;
            velocity[ch] = saturate(round_shift(-(vel * feedback), 16), STATE_BITS);
            return pos;
        endfunction

        function logic [SMP-1:0] mix_wet_dry(longint pos, longint dry);
            longint v;
            v = round_shift(pos * wet_q16 + dry * (UNITY - wet_q16), 16);
            v = saturate(v, SMP);
            return v[SMP-1:0];
        endfunction

        function void note_request(logic [TDATA_BITS-1:0] data);
            longint left_in;
            longint right_in;
            stereo_pair_t pair;
            left_in = longint'($signed(data[SMP-1:0]));
            right_in = longint'($signed(data[2*SMP-1:SMP]));
            pair.left = mix_wet_dry(smooth_channel(0, left_in), left_in);
            pair.right = mix_wet_dry(smooth_channel(1, right_in), right_in);
            expected_pairs.push_back(pair);
        endfunction

        function void report_mismatch(string field, logic [SMP-1:0] want,
                                      logic [SMP-1:0] got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s mismatch on result %0d: expected %06h, got %06h",
                         $realtime, field, results_checked, want, got);
            end
        endfunction

        function void check_result(logic [TDATA_BITS-1:0] data);
            stereo_pair_t want;
            results_checked++;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %06h/%06h arrived with no request pending",
                             $realtime, data[SMP-1:0], data[2*SMP-1:SMP]);
                end
                return;
            end
            want = expected_pairs.pop_front();
            if (data[SMP-1:0] !== want.left)
            begin
                report_mismatch("left_out", want.left, data[SMP-1:0]);
            end
            if (data[2*SMP-1:SMP] !== want.right)
            begin
                report_mismatch("right_out", want.right, data[2*SMP-1:SMP]);
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_TRIM;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // Fields from bit 0 up: left_sample, right_sample.
    logic [TDATA_BITS-1:0]     s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // Fields from bit 0 up: left_out, right_out.
    logic [TDATA_BITS-1:0]     m_axis_tdata;

    smoother_scoreboard sb = new();

    // Idle rates in percent per cycle; the main sequence changes them.
    int sender_idle_pct = 6;
    int receiver_idle_pct = 54;

    int quiet_cycles = 0;
    logic [SMP-1:0] prev_left = '0;
    logic [SMP-1:0] prev_right = '0;

    stereo_slope_fir_smoother DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one request after a random idle gap and hold it until the block
    // takes it. Inputs change at the falling edge only; tready is sampled at
    // the rising edge, before the block's registers update.
    task automatic send_pair(logic [SMP-1:0] left, logic [SMP-1:0] right);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= TDATA_BITS'({right, left});
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_request(TDATA_BITS'({right, left}));
        prev_left = left;
        prev_right = right;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Mostly full-range noise, with a good share of extremes, small values
    // near zero and repeated samples, so that both the saturation paths and
    // the fine rounding of the filter get exercised.
    function automatic logic [SMP-1:0] pick_sample(logic [SMP-1:0] prev);
        logic [SMP-1:0] v;
        case ($urandom_range(0, 11))
            0: v = 24'h7FFFFF;
            1: v = 24'h800000;
            2, 3: v = SMP'(int'($urandom_range(0, 512)) - 256);
            4: v = prev;
            default: v = SMP'($urandom());
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.apply_write(index, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Both knobs are written between phases, only once every expected result
    // is back. The second write waits until the weight derivation started by
    // the first one has finished, which the block shows by raising tready.
    task automatic configure(int trim, int wet);
        wait_drained();
        write_register(REG_TRIM, CFG_BITS'(trim));
        repeat (4) @(posedge clk);
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        write_register(REG_WET, CFG_BITS'(wet));
    endtask

    // Receiver: random stalls at the current rate, plus one long hold-off
    // early in the run while the sender keeps offering requests.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.results_checked >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Every result accepted at a rising edge goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: a run that goes too long without any handshake is hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset, the directed requests at the reset settings,
    // then one random burst per configuration phase. The first third of the
    // phases has a rarely idle sender and a often stalling receiver, the
    // second third the other way round, and the last third runs at full rate.
    initial
    begin
        int trim;
        int wet;
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 20; i++)
        begin
            send_pair(DIR_LEFT[i], DIR_RIGHT[i]);
        end
        end_burst();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 3)
            begin
                sender_idle_pct = 6;
                receiver_idle_pct = 54;
            end
            else if (phase < 6)
            begin
                sender_idle_pct = 54;
                receiver_idle_pct = 6;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            trim = (TRIM_PLAN[phase] < 0) ? int'($urandom_range(0, 131071))
                                          : TRIM_PLAN[phase];
            wet = (WET_PLAN[phase] < 0) ? int'($urandom_range(0, 131071))
                                        : WET_PLAN[phase];
            configure(trim, wet);
            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                send_pair(pick_sample(prev_left), pick_sample(prev_right));
            end
            end_burst();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
